/* hw/rtl/quaternion_gyro_integrator_macros.svh */
// ----------------------------------------------------------------------------
// quaternion_gyro_integrator_macros.svh
// Assertion macros shared by the checker of the gyro integrator
// ----------------------------------------------------------------------------
`ifndef QUATERNION_GYRO_INTEGRATOR_MACROS_SVH
`define QUATERNION_GYRO_INTEGRATOR_MACROS_SVH

// same-cycle implication under reset
`define QGI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qgi assertion failed");

// next-cycle implication under reset
`define QGI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qgi assertion failed");

`endif

/* hw/rtl/qgi_pkg.sv */
// ----------------------------------------------------------------------------
// qgi_pkg
// Types and constants of the quaternion gyro integrator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qgi_pkg;

    localparam int QUAT_W  = 32;
    localparam int RATE_W  = 32;
    localparam int STEP_W  = 24;
    localparam int MUL_W   = 34;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int ACC_W   = 40;
    localparam int A_W     = 33;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam logic [STEP_W-1:0] STEP_RESET = 24'd167772;
    localparam logic [QUAT_W-1:0] Q_ONE      = 32'h4000_0000;

    localparam logic [2:0] REG_STEP_TIME = 3'd0;
    localparam logic [2:0] REG_INIT_W    = 3'd1;
    localparam logic [2:0] REG_INIT_X    = 3'd2;
    localparam logic [2:0] REG_INIT_Y    = 3'd3;
    localparam logic [2:0] REG_INIT_Z    = 3'd4;

    typedef struct packed {
        logic start;
        logic sqrt_mode;
    } rd_cmd_t;

    typedef struct packed {
        logic [1:0] qsel;
        logic [1:0] asel;
        logic [1:0] ptgt;
        logic       neg;
    } term_t;

endpackage

`default_nettype wire

/* hw/rtl/qgi_mul.sv */
// ----------------------------------------------------------------------------
// qgi_mul
// Shared signed multiplier with registered product
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qgi_mul (
    input  logic                               clk,
    input  logic signed [qgi_pkg::MUL_W-1:0]   op_a,
    input  logic signed [qgi_pkg::MUL_W-1:0]   op_b,
    output logic signed [qgi_pkg::PROD_W-1:0]  prod_reg
);
    import qgi_pkg::*;

    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = op_a * op_b;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

endmodule

`default_nettype wire

/* hw/rtl/qgi_rootdiv.sv */
// ----------------------------------------------------------------------------
// qgi_rootdiv
// Bit-serial square root and divider sharing one compare-subtract step
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qgi_rootdiv (
    input  logic             clk,
    input  logic             rst_n,
    input  qgi_pkg::rd_cmd_t cmd,
    input  logic [63:0]      src,
    input  logic [31:0]      den,
    output logic             done,
    output logic [31:0]      result
);
    import qgi_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        mode_reg, mode_next;
    logic [35:0] rem_reg, rem_next;
    logic [31:0] acc_reg, acc_next;
    logic [63:0] sh_reg, sh_next;
    logic [31:0] den_reg, den_next;

    logic [35:0] cand;
    logic [35:0] trial;
    logic        ge;

    // root mode brings in two bits a step, divide mode one
    assign cand  = mode_reg ? {rem_reg[33:0], sh_reg[63:62]} : {rem_reg[34:0], sh_reg[63]};
    assign trial = mode_reg ? {2'b00, acc_reg, 2'b01} : {4'b0000, den_reg};
    assign ge    = (cand >= trial);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mode_next = mode_reg;
        rem_next  = rem_reg;
        acc_next  = acc_reg;
        sh_next   = sh_reg;
        den_next  = den_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            mode_next = cmd.sqrt_mode;
            acc_next  = 32'd0;
            den_next  = den;
            if (cmd.sqrt_mode)
            begin
                rem_next = 36'd0;
                sh_next  = src;
            end
            else
            begin
                rem_next = {4'b0000, src[63:32]};
                sh_next  = {src[31:0], 32'd0};
            end
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (cand - trial) : cand;
            acc_next = {acc_reg[30:0], ge};
            sh_next  = mode_reg ? {sh_reg[61:0], 2'b00} : {sh_reg[62:0], 1'b0};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
            mode_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            mode_reg <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        acc_reg <= acc_next;
        sh_reg  <= sh_next;
        den_reg <= den_next;
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

`default_nettype wire

/* hw/rtl/quaternion_gyro_integrator.sv */
// ----------------------------------------------------------------------------
// quaternion_gyro_integrator
// First-order attitude quaternion integration from gyro rate samples
// ----------------------------------------------------------------------------
// usage:
//   input transaction: rate_x/y/z (Q8.24 rad/s) on in_valid, refused by in_stall
//   output transaction: q_w/x/y/z (Q1.30) and zero_norm on out_valid/out_stall
//   apb port: step_time at 0x00, init_w/x/y/z at 0x04..0x10; writing an init
//   register also loads that attitude component
// processing steps:
//   products on the shared multiplier, a check step, a square root and four
//   divisions on the shared root/divide unit, then an output step; a new
//   transaction is taken only after the last one has left the output step
//   a zero norm skips root and divide
// in_stall is high while a transaction is in work; a waiting result does not
// block the next input, but the block holds its next result until the output
// register is taken
// reset loads the identity attitude and the register reset values
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module quaternion_gyro_integrator (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [qgi_pkg::RATE_W-1:0] rate_x,
    input  logic signed [qgi_pkg::RATE_W-1:0] rate_y,
    input  logic signed [qgi_pkg::RATE_W-1:0] rate_z,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [qgi_pkg::QUAT_W-1:0] q_w,
    output logic signed [qgi_pkg::QUAT_W-1:0] q_x,
    output logic signed [qgi_pkg::QUAT_W-1:0] q_y,
    output logic signed [qgi_pkg::QUAT_W-1:0] q_z,
    output logic                             zero_norm,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [qgi_pkg::ADDR_W-1:0]       paddr,
    input  logic [qgi_pkg::DATA_W-1:0]       pwdata,
    output logic [qgi_pkg::DATA_W-1:0]       prdata,
    output logic                             pready
);
    import qgi_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_CHK  = 3'd2;
    localparam logic [2:0] ST_ROOT = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    localparam logic [4:0] OP_LAST_RATE = 5'd2;
    localparam logic [4:0] OP_LAST_TERM = 5'd14;
    localparam logic [4:0] OP_LAST_SQ   = 5'd18;
    localparam logic [4:0] OP_END       = 5'd19;

    logic [2:0]               state_reg, state_next;
    logic [4:0]               idx_reg, idx_next;
    logic [1:0]               k_reg, k_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic signed [QUAT_W-1:0] init_reg [4];
    logic signed [QUAT_W-1:0] init_next [4];
    logic signed [QUAT_W-1:0] att_reg [4];
    logic signed [QUAT_W-1:0] att_next [4];
    logic signed [RATE_W-1:0] rate_reg [3];
    logic signed [RATE_W-1:0] rate_next [3];
    logic signed [A_W-1:0]    a_reg [3];
    logic signed [A_W-1:0]    a_next [3];
    logic signed [ACC_W-1:0]  p_reg [4];
    logic signed [ACC_W-1:0]  p_next [4];
    logic [63:0]              sum_reg, sum_next;
    logic [31:0]              root_reg, root_next;
    logic                     zflag_reg, zflag_next;
    logic                     ov_reg, ov_next;
    logic signed [QUAT_W-1:0] oq_reg [4];
    logic signed [QUAT_W-1:0] oq_next [4];
    logic                     oz_reg, oz_next;

    logic signed [MUL_W-1:0]  op_a, op_b;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] rnd_a, rnd_t;
    logic signed [QUAT_W-1:0] pc [4];
    logic [4:0]               cidx;
    logic [4:0]               sq_idx;
    term_t                    iss_t, con_t;

    rd_cmd_t                  rd_cmd;
    logic [63:0]              rd_src;
    logic [31:0]              rd_den;
    logic                     rd_done;
    logic [31:0]              rd_result;
    logic [1:0]               kd;
    logic [31:0]              pmag;
    logic [31:0]              qsat;

    logic                     in_acc;
    logic                     cfg_wr;

    function automatic term_t term_map(input logic [4:0] op);
        term_t t;
        t = '0;
        unique case (op)
            5'd3:    t = '{qsel: 2'd1, asel: 2'd0, ptgt: 2'd0, neg: 1'b1};
            5'd4:    t = '{qsel: 2'd2, asel: 2'd1, ptgt: 2'd0, neg: 1'b1};
            5'd5:    t = '{qsel: 2'd3, asel: 2'd2, ptgt: 2'd0, neg: 1'b1};
            5'd6:    t = '{qsel: 2'd0, asel: 2'd0, ptgt: 2'd1, neg: 1'b0};
            5'd7:    t = '{qsel: 2'd2, asel: 2'd2, ptgt: 2'd1, neg: 1'b0};
            5'd8:    t = '{qsel: 2'd3, asel: 2'd1, ptgt: 2'd1, neg: 1'b1};
            5'd9:    t = '{qsel: 2'd0, asel: 2'd1, ptgt: 2'd2, neg: 1'b0};
            5'd10:   t = '{qsel: 2'd1, asel: 2'd2, ptgt: 2'd2, neg: 1'b1};
            5'd11:   t = '{qsel: 2'd3, asel: 2'd0, ptgt: 2'd2, neg: 1'b0};
            5'd12:   t = '{qsel: 2'd0, asel: 2'd2, ptgt: 2'd3, neg: 1'b0};
            5'd13:   t = '{qsel: 2'd1, asel: 2'd1, ptgt: 2'd3, neg: 1'b0};
            5'd14:   t = '{qsel: 2'd2, asel: 2'd0, ptgt: 2'd3, neg: 1'b1};
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic logic signed [A_W-1:0] clamp_a(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] lim;
        lim = 68'sh0_FFFF_FFFF;
        if (v > lim)
            return lim[A_W-1:0];
        else if (v < -lim)
            return A_W'(-lim);
        else
            return v[A_W-1:0];
    endfunction

    function automatic logic signed [QUAT_W-1:0] clamp_p(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] lim;
        lim = 40'sh00_7FFF_FFFF;
        if (v > lim)
            return lim[QUAT_W-1:0];
        else if (v < -lim)
            return QUAT_W'(-lim);
        else
            return v[QUAT_W-1:0];
    endfunction

    assign in_acc = in_valid && !in_stall;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            pc[i] = clamp_p(p_reg[i]);
        end
    end

    // operand selection for the product issued this cycle
    assign iss_t  = term_map(idx_reg);
    assign sq_idx = idx_reg - 5'd15;

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        if (idx_reg <= OP_LAST_RATE)
        begin
            op_a = MUL_W'(rate_reg[idx_reg[1:0]]);
            op_b = {{(MUL_W-STEP_W){1'b0}}, step_reg};
        end
        else if (idx_reg <= OP_LAST_TERM)
        begin
            op_a = MUL_W'(att_reg[iss_t.qsel]);
            op_b = MUL_W'(a_reg[iss_t.asel]);
        end
        else if (idx_reg <= OP_LAST_SQ)
        begin
            op_a = MUL_W'(pc[sq_idx[1:0]]);
            op_b = MUL_W'(pc[sq_idx[1:0]]);
        end
    end

    qgi_mul u_mul (
        .clk      (clk),
        .op_a     (op_a),
        .op_b     (op_b),
        .prod_reg (prod_reg)
    );

    // round half up on the discarded bits
    assign rnd_a = (prod_reg + 68'sd262144) >>> 19;
    assign rnd_t = (prod_reg + 68'sd536870912) >>> 30;
    assign cidx  = idx_reg - 5'd1;
    assign con_t = term_map(cidx);

    // division operands
    assign kd     = (state_reg == ST_ROOT) ? 2'd0 : (k_reg + 2'd1);
    assign rd_den = (state_reg == ST_ROOT) ? rd_result : root_reg;
    assign pmag   = pc[kd][QUAT_W-1] ? (32'd0 - pc[kd]) : pc[kd];

    always_comb
    begin
        rd_cmd = '0;
        rd_src = {3'b000, pmag[30:0], 30'd0} + {33'd0, rd_den[31:1]};
        unique case (state_reg)
            ST_CHK:
            begin
                rd_cmd.start     = (sum_reg != 64'd0);
                rd_cmd.sqrt_mode = 1'b1;
                rd_src           = sum_reg;
            end
            ST_ROOT:
            begin
                rd_cmd.start = rd_done;
            end
            ST_DIV:
            begin
                rd_cmd.start = rd_done && (k_reg != 2'd3);
            end
            default:
            begin
                rd_cmd = '0;
            end
        endcase
    end

    qgi_rootdiv u_rootdiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (rd_cmd),
        .src    (rd_src),
        .den    (rd_den),
        .done   (rd_done),
        .result (rd_result)
    );

    assign qsat = (rd_result > Q_ONE) ? Q_ONE : rd_result;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        k_next     = k_reg;
        step_next  = step_reg;
        sum_next   = sum_reg;
        root_next  = root_reg;
        zflag_next = zflag_reg;
        ov_next    = ov_reg;
        oz_next    = oz_reg;
        for (int i = 0; i < 4; i++)
        begin
            init_next[i] = init_reg[i];
            att_next[i]  = att_reg[i];
            p_next[i]    = p_reg[i];
            oq_next[i]   = oq_reg[i];
        end
        for (int i = 0; i < 3; i++)
        begin
            rate_next[i] = rate_reg[i];
            a_next[i]    = a_reg[i];
        end

        if (ov_reg && !out_stall)
            ov_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    rate_next[0] = rate_x;
                    rate_next[1] = rate_y;
                    rate_next[2] = rate_z;
                    for (int i = 0; i < 4; i++)
                    begin
                        p_next[i] = ACC_W'(att_reg[i]);
                    end
                    sum_next   = 64'd0;
                    idx_next   = 5'd0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                // take in the product issued last cycle
                if (idx_reg != 5'd0)
                begin
                    if (cidx <= OP_LAST_RATE)
                        a_next[cidx[1:0]] = clamp_a(rnd_a);
                    else if (cidx <= OP_LAST_TERM)
                        p_next[con_t.ptgt] = con_t.neg ?
                            (p_reg[con_t.ptgt] - rnd_t[ACC_W-1:0]) :
                            (p_reg[con_t.ptgt] + rnd_t[ACC_W-1:0]);
                    else
                        sum_next = sum_reg + prod_reg[63:0];
                end
                idx_next = idx_reg + 5'd1;
                if (idx_reg == OP_END)
                    state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (sum_reg == 64'd0)
                begin
                    zflag_next = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    zflag_next = 1'b0;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (rd_done)
                begin
                    root_next  = rd_result;
                    k_next     = 2'd0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // k_reg holds the component under division
                if (rd_done)
                begin
                    att_next[k_reg] = pc[k_reg][QUAT_W-1] ? (32'sd0 - qsat) : qsat;
                end
                if (rd_cmd.start)
                    k_next = kd;
                else if (rd_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next = 1'b1;
                    oz_next = zflag_reg;
                    for (int i = 0; i < 4; i++)
                    begin
                        oq_next[i] = att_reg[i];
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_STEP_TIME: step_next = pwdata[STEP_W-1:0];
                REG_INIT_W:
                begin
                    init_next[0] = pwdata;
                    att_next[0]  = pwdata;
                end
                REG_INIT_X:
                begin
                    init_next[1] = pwdata;
                    att_next[1]  = pwdata;
                end
                REG_INIT_Y:
                begin
                    init_next[2] = pwdata;
                    att_next[2]  = pwdata;
                end
                REG_INIT_Z:
                begin
                    init_next[3] = pwdata;
                    att_next[3]  = pwdata;
                end
                default:
                begin
                    step_next = step_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_STEP_TIME: prdata = {{(DATA_W-STEP_W){1'b0}}, step_reg};
            REG_INIT_W:    prdata = init_reg[0];
            REG_INIT_X:    prdata = init_reg[1];
            REG_INIT_Y:    prdata = init_reg[2];
            REG_INIT_Z:    prdata = init_reg[3];
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= 5'd0;
            k_reg     <= 2'd0;
            step_reg  <= STEP_RESET;
            zflag_reg <= 1'b0;
            ov_reg    <= 1'b0;
            init_reg[0] <= Q_ONE;
            att_reg[0]  <= Q_ONE;
            for (int i = 1; i < 4; i++)
            begin
                init_reg[i] <= '0;
                att_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            k_reg     <= k_next;
            step_reg  <= step_next;
            zflag_reg <= zflag_next;
            ov_reg    <= ov_next;
            for (int i = 0; i < 4; i++)
            begin
                init_reg[i] <= init_next[i];
                att_reg[i]  <= att_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        root_reg <= root_next;
        oz_reg   <= oz_next;
        for (int i = 0; i < 4; i++)
        begin
            p_reg[i]  <= p_next[i];
            oq_reg[i] <= oq_next[i];
        end
        for (int i = 0; i < 3; i++)
        begin
            rate_reg[i] <= rate_next[i];
            a_reg[i]    <= a_next[i];
        end
    end

    assign out_valid = ov_reg;
    assign q_w       = oq_reg[0];
    assign q_x       = oq_reg[1];
    assign q_y       = oq_reg[2];
    assign q_z       = oq_reg[3];
    assign zero_norm = oz_reg;

endmodule

`default_nettype wire

/* hw/rtl/qgi_checker.sv */
// ----------------------------------------------------------------------------
// qgi_checker
// Port-level assertions for the quaternion gyro integrator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "quaternion_gyro_integrator_macros.svh"

module qgi_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic signed [qgi_pkg::QUAT_W-1:0] q_w,
    input logic signed [qgi_pkg::QUAT_W-1:0] q_x,
    input logic signed [qgi_pkg::QUAT_W-1:0] q_y,
    input logic signed [qgi_pkg::QUAT_W-1:0] q_z,
    input logic                              zero_norm,
    input logic                              psel,
    input logic                              penable,
    input logic                              pready
);
    import qgi_pkg::*;

    // a stalled result stays offered and unchanged
    `QGI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `QGI_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(q_w) && $stable(q_x) && $stable(q_y) && $stable(q_z) && $stable(zero_norm))

    // an accepted transaction keeps the block busy, with in_stall held high
    `QGI_ASSERT_IMPL(a_busy, clk, rst_n, in_valid && !in_stall, ##1 in_stall ##1 in_stall)

    // register accesses complete without wait states
    `QGI_ASSERT_IMPL(a_pready, clk, rst_n, psel && penable, pready)

endmodule

bind quaternion_gyro_integrator qgi_checker u_qgi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .q_w       (q_w),
    .q_x       (q_x),
    .q_y       (q_y),
    .q_z       (q_z),
    .zero_norm (zero_norm),
    .psel      (psel),
    .penable   (penable),
    .pready    (pready)
);

`default_nettype wire

/* verif/tb_quaternion_gyro_integrator.sv */
// ----------------------------------------------------------------------------
// tb_quaternion_gyro_integrator
// Self-checking bench: directed and random gyro samples are sent through the
// valid/stall channel, and each output transaction is compared field by field
// with a fixed-point attitude predictor. Registers are written over the APB
// port between phases, and sender and receiver idle in several patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_quaternion_gyro_integrator;
    import qgi_pkg::*;

    localparam logic [2:0] REG_UNMAPPED = 3'd6;
    localparam longint     A_SAT        = 64'sh0_FFFF_FFFF;
    localparam longint     P_SAT        = 64'sh0_7FFF_FFFF;
    localparam longint     Q_SAT        = 64'sh0_4000_0000;
    localparam int         DRAIN_CYCLES = 400;
    localparam int         CYCLE_LIMIT  = 3000000;

    typedef struct packed {
        logic signed [QUAT_W-1:0] w;
        logic signed [QUAT_W-1:0] x;
        logic signed [QUAT_W-1:0] y;
        logic signed [QUAT_W-1:0] z;
        logic                     zn;
    } attitude_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic signed [RATE_W-1:0]  rate_x;
    logic signed [RATE_W-1:0]  rate_y;
    logic signed [RATE_W-1:0]  rate_z;
    logic                      out_valid;
    logic                      out_stall;
    logic signed [QUAT_W-1:0]  q_w;
    logic signed [QUAT_W-1:0]  q_x;
    logic signed [QUAT_W-1:0]  q_y;
    logic signed [QUAT_W-1:0]  q_z;
    logic                      zero_norm;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [ADDR_W-1:0]         paddr;
    logic [DATA_W-1:0]         pwdata;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;

    // predictor state
    longint    step_dt;
    longint    att[4];
    attitude_t expected_att[$];

    int        errors;
    int        cycles;
    int        send_idle_pct;
    int        recv_stall_pct;

    quaternion_gyro_integrator u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .rate_x(rate_x), .rate_y(rate_y), .rate_z(rate_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .q_w(q_w), .q_x(q_x), .q_y(q_y), .q_z(q_z), .zero_norm(zero_norm),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic longint clamp_sym(input longint v, input longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // round half up: add half an lsb, then floor
    function automatic longint round_sh(input longint v, input int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic bit [63:0] floor_sqrt(input bit [63:0] v);
        bit [63:0] r;
        bit [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint normalize(input longint p, input bit [63:0] nrm);
        bit [63:0] mag;
        bit [63:0] qm;
        longint    q;
        mag = (p < 0) ? 64'(-p) : 64'(p);
        mag = mag << 30;
        qm  = (mag + nrm / 2) / nrm;
        q   = (qm > 64'(Q_SAT)) ? Q_SAT : longint'(qm);
        return (p < 0) ? -q : q;
    endfunction

    function automatic longint xterm(input longint qc, input longint a);
        return round_sh(qc * a, 30);
    endfunction

    function automatic attitude_t integrate_rates(input logic signed [RATE_W-1:0] rx,
                                                  input logic signed [RATE_W-1:0] ry,
                                                  input logic signed [RATE_W-1:0] rz);
        longint    a[3];
        longint    p[4];
        longint    w, x, y, z;
        bit [63:0] sum;
        bit [63:0] m;
        attitude_t res;
        w = att[0];
        x = att[1];
        y = att[2];
        z = att[3];
        a[0] = clamp_sym(round_sh(longint'(rx) * step_dt, 19), A_SAT);
        a[1] = clamp_sym(round_sh(longint'(ry) * step_dt, 19), A_SAT);
        a[2] = clamp_sym(round_sh(longint'(rz) * step_dt, 19), A_SAT);
        p[0] = w - xterm(x, a[0]) - xterm(y, a[1]) - xterm(z, a[2]);
        p[1] = xterm(w, a[0]) + x + xterm(y, a[2]) - xterm(z, a[1]);
        p[2] = xterm(w, a[1]) - xterm(x, a[2]) + y + xterm(z, a[0]);
        p[3] = xterm(w, a[2]) + xterm(x, a[1]) - xterm(y, a[0]) + z;
        sum = 0;
        for (int i = 0; i < 4; i++)
        begin
            p[i] = clamp_sym(p[i], P_SAT);
            m    = (p[i] < 0) ? 64'(-p[i]) : 64'(p[i]);
            sum  = sum + m * m;
        end
        if (sum == 0)
            res.zn = 1'b1;
        else
        begin
            for (int i = 0; i < 4; i++)
                att[i] = normalize(p[i], floor_sqrt(sum));
            res.zn = 1'b0;
        end
        res.w = att[0][31:0];
        res.x = att[1][31:0];
        res.y = att[2][31:0];
        res.z = att[3][31:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        errors++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        attitude_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_att.size() == 0)
                report_mismatch("unexpected transaction", {31'd0, zero_norm}, 32'd0);
            else
            begin
                e = expected_att.pop_front();
                if (q_w !== e.w)
                    report_mismatch("q_w", q_w, e.w);
                if (q_x !== e.x)
                    report_mismatch("q_x", q_x, e.x);
                if (q_y !== e.y)
                    report_mismatch("q_y", q_y, e.y);
                if (q_z !== e.z)
                    report_mismatch("q_z", q_z, e.z);
                if (zero_norm !== e.zn)
                    report_mismatch("zero_norm", zero_norm, e.zn);
            end
        end
    end

    always @(negedge clk)
        out_stall = ($urandom_range(99) < recv_stall_pct);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_rates(input logic [31:0] rx, input logic [31:0] ry,
                              input logic [31:0] rz);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            rate_x   = $urandom;
            rate_y   = $urandom;
            rate_z   = $urandom;
            @(negedge clk);
        end
        in_valid = 1'b1;
        rate_x   = rx;
        rate_y   = ry;
        rate_z   = rz;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        expected_att.push_back(integrate_rates(rx, ry, rz));
    endtask

    // let the block drain before touching registers
    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_att.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (idx == REG_STEP_TIME)
            step_dt = longint'(val[STEP_W-1:0]);
        else if (idx <= REG_INIT_Z)
            att[idx - 1] = longint'(signed'(val));
    endtask

    task automatic load_attitude(input logic [31:0] w, input logic [31:0] x,
                                 input logic [31:0] y, input logic [31:0] z);
        write_reg(REG_INIT_W, w);
        write_reg(REG_INIT_X, x);
        write_reg(REG_INIT_Y, y);
        write_reg(REG_INIT_Z, z);
    endtask

    task automatic set_idling(input int phase);
        case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
            default: begin send_idle_pct = 19; recv_stall_pct = 19; end
        endcase
    endtask

    function automatic logic [31:0] rand_rate();
        logic [31:0] r;
        r = $urandom;
        // mostly gentle rates, sometimes the full range
        if ($urandom_range(3) != 0)
            r = 32'(signed'(r) >>> $urandom_range(12, 4));
        return r;
    endfunction

    function automatic logic [31:0] rand_comp();
        return 32'(signed'($urandom_range(32'h8000_0000, 0)) - 32'sh4000_0000);
    endfunction

    task automatic test_reset_identity();
        send_rates(32'd0, 32'd0, 32'd0);
        send_rates(32'h0100_0000, 32'd0, 32'd0);
        send_rates(32'd0, 32'hFF00_0000, 32'h0080_0000);
    endtask

    task automatic test_rate_extremes();
        wait_idle();
        write_reg(REG_STEP_TIME, 32'h00FF_FFFF);
        send_rates(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_rates(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_rates(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
        send_rates(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F);
        wait_idle();
        write_reg(REG_STEP_TIME, 32'd0);
        send_rates(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678);
        wait_idle();
        write_reg(REG_STEP_TIME, 32'd1);
        send_rates(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    endtask

    task automatic test_zero_norm();
        wait_idle();
        write_reg(REG_STEP_TIME, 32'd167772);
        load_attitude(32'd0, 32'd0, 32'd0, 32'd0);
        send_rates(32'h0100_0000, 32'hFF00_0000, 32'h0200_0000);
        send_rates(32'd0, 32'd0, 32'd0);
        wait_idle();
        // zero attitude, whose cross terms are all zero even under extreme rates
        load_attitude(32'd0, 32'd0, 32'd0, 32'd0);
        send_rates(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        wait_idle();
        // out-of-range init values and unmapped registers
        load_attitude(32'h8000_0000, 32'h7FFF_FFFF, 32'hC000_0000, 32'h4000_0000);
        write_reg(REG_UNMAPPED, $urandom);
        write_reg(3'd7, $urandom);
        write_reg(3'd5, $urandom);
        send_rates(32'h0010_0000, 32'h0020_0000, 32'hFFF0_0000);
        wait_idle();
        load_attitude(32'h4000_0000, 32'hC000_0000, 32'h4000_0000, 32'hC000_0000);
        send_rates(32'd0, 32'd0, 32'd0);
        send_rates(32'h0300_0000, 32'h0300_0000, 32'h0300_0000);
    endtask

    task automatic test_random();
        logic [31:0] dt;
        for (int seg = 0; seg < 8; seg++)
        begin
            wait_idle();
            set_idling(seg);
            case (seg % 3)
                0: dt = $urandom_range(400000);
                1: dt = $urandom & 32'h00FF_FFFF;
                default: dt = (seg == 2) ? 32'h00FF_FFFF : 32'd167772;
            endcase
            write_reg(REG_STEP_TIME, dt);
            if (seg % 2 == 1)
                load_attitude(rand_comp(), rand_comp(), rand_comp(), rand_comp());
            else
                load_attitude(32'h4000_0000, 32'd0, 32'd0, 32'd0);
            for (int n = 0; n < 165; n++)
                send_rates(rand_rate(), rand_rate(), rand_rate());
        end
    endtask

    initial
    begin
        errors         = 0;
        cycles         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        out_stall      = 1'b0;
        rate_x         = '0;
        rate_y         = '0;
        rate_z         = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        step_dt        = 167772;
        att[0]         = Q_SAT;
        att[1]         = 0;
        att[2]         = 0;
        att[3]         = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        test_reset_identity();
        test_rate_extremes();
        test_zero_norm();
        test_random();

        wait_idle();
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
